// ===== hw/rtl/rhsl_pkg.sv =====
`timescale 1ns / 1ps

package rhsl_pkg;

	// quotient bits per divide, one per cell
	localparam int QUO_W = 16;
	// partial remainder and divisor width (divisor is at most 510)
	localparam int REM_W = 9;
	// numerator width seen by a divide lane
	localparam int NUM_W = QUO_W + REM_W;
	localparam int LIG_W = 16;
	localparam int HUE_W = 15;

	// one full turn in hue units (360 degrees times 64)
	localparam logic [QUO_W-1:0] HUE_FULL = 16'd23040;

	// hue sector of the largest channel, as a multiple of two sixths of a turn
	localparam logic [1:0] SEC_RED      = 2'd0;
	localparam logic [1:0] SEC_GREEN    = 2'd1;
	localparam logic [1:0] SEC_BLUE     = 2'd2;
	localparam logic [1:0] SEC_RED_WRAP = 2'd3;

	// restoring divide lane: numerator bits shift out the top of bits,
	// quotient bits shift in at the bottom
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] den;
		logic [QUO_W-1:0] bits;
	} lane_t;

	// data that rides along the divide chain untouched
	typedef struct packed {
		logic             gray;
		logic [LIG_W-1:0] lig;
	} side_t;

endpackage

// ===== hw/rtl/rhsl_front.sv =====
`timescale 1ns / 1ps

module rhsl_front import rhsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	output lane_t      out_sat,
	output lane_t      out_hue,
	output side_t      out_side
);

	// stage 1: max, min, sector and channel difference
	logic              red_max, green_max;
	logic [7:0]        mx_c, mn_c;
	logic [1:0]        sec_c;
	logic signed [8:0] diff_c;

	logic              valid_s1;
	logic [7:0]        mx_s1, mn_s1;
	logic [1:0]        sec_s1;
	logic signed [8:0] diff_s1;

	always_comb begin
		red_max   = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		if (red_max) begin
			mx_c   = red;
			sec_c  = (green < blue) ? SEC_RED_WRAP : SEC_RED;
			diff_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green_max) begin
			mx_c   = green;
			sec_c  = SEC_GREEN;
			diff_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			mx_c   = blue;
			sec_c  = SEC_BLUE;
			diff_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end
		if ((red <= green) && (red <= blue)) begin
			mn_c = red;
		end else if (green <= blue) begin
			mn_c = green;
		end else begin
			mn_c = blue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1   <= mx_c;
		mn_s1   <= mn_c;
		sec_s1  <= sec_c;
		diff_s1 <= diff_c;
	end

	// stage 2: delta, sum and the sector value scaled by delta
	logic [7:0]  delta_c;
	logic [8:0]  sum_c;
	logic [10:0] kd_c, m_c;

	logic        valid_s2;
	logic [7:0]  delta_s2;
	logic [8:0]  sum_s2;
	logic [10:0] m_s2;

	always_comb begin
		delta_c = mx_s1 - mn_s1;
		sum_c   = {1'b0, mx_s1} + {1'b0, mn_s1};
		case (sec_s1)
			SEC_GREEN:    kd_c = {2'b0, delta_c, 1'b0};
			SEC_BLUE:     kd_c = {1'b0, delta_c, 2'b0};
			SEC_RED_WRAP: kd_c = {1'b0, delta_c, 2'b0} + {2'b0, delta_c, 1'b0};
			default:      kd_c = 11'd0;
		endcase
		// never negative: the sector offset covers the signed difference
		m_c = kd_c + {{2{diff_s1[8]}}, diff_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		delta_s2 <= delta_c;
		sum_s2   <= sum_c;
		m_s2     <= m_c;
	end

	// stage 3: divide operands with the half-up rounding folded in
	logic [7:0]       den_c;
	logic [NUM_W-1:0] sat_num_c, hue_num_c;
	logic [16:0]      lig_c;

	logic             valid_s3;
	lane_t            sat_s3, hue_s3;
	side_t            side_s3;

	always_comb begin
		den_c = (sum_s2 < 9'd255) ? sum_s2[7:0] : 8'(9'd510 - sum_s2);
		// 2*65535*delta + den over 2*den
		sat_num_c = {delta_s2, 17'd0} - {16'd0, delta_s2, 1'b0} + {17'd0, den_c};
		// 2*3840*m + delta over 2*delta
		hue_num_c = {1'b0, m_s2, 13'd0} - {5'd0, m_s2, 9'd0} + {17'd0, delta_s2};
		// (sum*257 + 1) / 2
		lig_c = {sum_s2, 8'd0} + {8'd0, sum_s2} + 17'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sat_s3.rem   <= sat_num_c[NUM_W-1:QUO_W];
		sat_s3.bits  <= sat_num_c[QUO_W-1:0];
		sat_s3.den   <= {den_c, 1'b0};
		hue_s3.rem   <= hue_num_c[NUM_W-1:QUO_W];
		hue_s3.bits  <= hue_num_c[QUO_W-1:0];
		hue_s3.den   <= {delta_s2, 1'b0};
		side_s3.gray <= (delta_s2 == 8'd0);
		side_s3.lig  <= lig_c[16:1];
	end

	assign out_valid = valid_s3;
	assign out_sat   = sat_s3;
	assign out_hue   = hue_s3;
	assign out_side  = side_s3;

endmodule

// ===== hw/rtl/rhsl_cell.sv =====
`timescale 1ns / 1ps

module rhsl_cell import rhsl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  lane_t in_sat,
	input  lane_t in_hue,
	input  side_t in_side,
	output logic  out_valid,
	output lane_t out_sat,
	output lane_t out_hue,
	output side_t out_side
);

	// one restoring step: bring down a numerator bit, subtract if it fits
	function automatic lane_t div_step(input lane_t l);
		logic [REM_W:0] trial;
		logic           fits;
		lane_t          r;
		trial  = {l.rem, l.bits[QUO_W-1]};
		fits   = (trial >= {1'b0, l.den});
		r.den  = l.den;
		r.rem  = fits ? REM_W'(trial - {1'b0, l.den}) : trial[REM_W-1:0];
		r.bits = {l.bits[QUO_W-2:0], fits};
		return r;
	endfunction

	logic  valid_q;
	lane_t sat_q, hue_q;
	side_t side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sat_q  <= div_step(in_sat);
		hue_q  <= div_step(in_hue);
		side_q <= in_side;
	end

	assign out_valid = valid_q;
	assign out_sat   = sat_q;
	assign out_hue   = hue_q;
	assign out_side  = side_q;

endmodule

// ===== hw/rtl/rgb_to_hsl_converter.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// pixel     in   start / busy  red[7:0] green[7:0] blue[7:0]
// color     out  done          hue[14:0] saturation[15:0] lightness[15:0]
//
// A word is taken on every cycle with start high; busy stays low.
// Each result passes through 3 front stages, 16 divide cells
// (one quotient bit each for saturation and hue), and the output
// register. Reset clears only the valid bits of the chain.
// There is no stall path: done is a one-cycle strobe.

module rgb_to_hsl_converter import rhsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	output logic              done,
	output logic [HUE_W-1:0]  hue,
	output logic [QUO_W-1:0]  saturation,
	output logic [LIG_W-1:0]  lightness
);

	localparam int LATENCY = QUO_W + 4;

	logic  valid_c [QUO_W+1];
	lane_t sat_c   [QUO_W+1];
	lane_t hue_c   [QUO_W+1];
	side_t side_c  [QUO_W+1];

	rhsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (valid_c[0]),
		.out_sat   (sat_c[0]),
		.out_hue   (hue_c[0]),
		.out_side  (side_c[0])
	);

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		rhsl_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_sat    (sat_c[i]),
			.in_hue    (hue_c[i]),
			.in_side   (side_c[i]),
			.out_valid (valid_c[i+1]),
			.out_sat   (sat_c[i+1]),
			.out_hue   (hue_c[i+1]),
			.out_side  (side_c[i+1])
		);
	end

	// wrap a full turn, zero hue and saturation for gray
	logic [QUO_W-1:0] hue_q_c;
	logic [HUE_W-1:0] hue_c_w;

	always_comb begin
		hue_q_c = hue_c[QUO_W].bits;
		hue_c_w = (hue_q_c >= HUE_FULL) ? HUE_W'(hue_q_c - HUE_FULL) : hue_q_c[HUE_W-1:0];
	end

	logic             done_q;
	logic [HUE_W-1:0] hue_q;
	logic [QUO_W-1:0] sat_q;
	logic [LIG_W-1:0] lig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_c[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		hue_q <= side_c[QUO_W].gray ? '0 : hue_c_w;
		sat_q <= side_c[QUO_W].gray ? '0 : sat_c[QUO_W].bits;
		lig_q <= side_c[QUO_W].lig;
	end

	assign busy       = 1'b0;
	assign done       = done_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign lightness  = lig_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("pixel did not produce a result after the pipeline latency");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hue < HUE_W'(HUE_FULL)))
		else $error("hue not wrapped below a full turn");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (lightness == '0)) |-> ((saturation == '0) && (hue == '0)))
		else $error("black pixel gave nonzero hue or saturation");

endmodule

// ===== tb/sv/rgb_to_hsl_converter_tb.sv =====
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;
	import rhsl_pkg::*;

	localparam int HUE_SECTOR = 3840;
	localparam int FRAC_SCALE = 65535;
	localparam int RANDOM_PIXELS = 800;
	localparam int DRAIN_CYCLES = 30;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [QUO_W-1:0] sat;
		logic [LIG_W-1:0] lig;
	} hsl_t;

	// typed = 1: want holds the expected color, else it comes from predict_hsl
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       typed;
		hsl_t       want;
	} pixel_case_t;

	localparam int N_DIRECTED = 22;
	localparam pixel_case_t DIRECTED [0:N_DIRECTED-1] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd0,     16'd0}},
		'{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     16'd0,     16'd65535}},
		'{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     16'd65535, 16'd32768}},
		'{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  16'd65535, 16'd32768}},
		'{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 16'd65535, 16'd32768}},
		'{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  16'd65535, 16'd32768}},
		'{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 16'd65535, 16'd32768}},
		'{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 16'd65535, 16'd32768}},
		'{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     16'd0,     16'd32896}},
		'{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     16'd0,     16'd257}},
		// hue just short of a full turn, then a delta of one
		'{8'd255, 8'd0,   8'd1,   1'b0, '0},
		'{8'd1,   8'd0,   8'd0,   1'b0, '0},
		'{8'd254, 8'd255, 8'd255, 1'b0, '0},
		// ties for the largest channel
		'{8'd200, 8'd200, 8'd100, 1'b0, '0},
		'{8'd100, 8'd200, 8'd200, 1'b0, '0},
		'{8'd200, 8'd100, 8'd200, 1'b0, '0},
		// saturation denominator switches around mx+mn = 255, then mixed colors
		'{8'd200, 8'd54,  8'd0,   1'b0, '0},
		'{8'd200, 8'd55,  8'd0,   1'b0, '0},
		'{8'd200, 8'd56,  8'd0,   1'b0, '0},
		'{8'd170, 8'd85,  8'd15,  1'b0, '0},
		'{8'd85,  8'd170, 8'd240, 1'b0, '0},
		'{8'd15,  8'd240, 8'd170, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [7:0] red = 8'd0;
	logic [7:0] green = 8'd0;
	logic [7:0] blue = 8'd0;
	logic busy;
	logic done;
	logic [HUE_W-1:0] hue;
	logic [QUO_W-1:0] saturation;
	logic [LIG_W-1:0] lightness;

	hsl_t color_q[$];
	int errors = 0;
	int pixels_sent = 0;
	int colors_seen = 0;
	int gray_sent = 0;
	int tie_sent = 0;
	int burst_left = 0;

	rgb_to_hsl_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.red(red),
		.green(green),
		.blue(blue),
		.done(done),
		.hue(hue),
		.saturation(saturation),
		.lightness(lightness)
	);

	always #4 clk = ~clk;

	function automatic longint div_half_up(input longint num, input longint den);
		return (2 * num + den) / (2 * den);
	endfunction

	function automatic hsl_t predict_hsl(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		longint rr, gg, bb, mx, mn, delta, sum, den, num, h;
		hsl_t res;
		rr = longint'(r);
		gg = longint'(g);
		bb = longint'(b);
		mx = rr;
		mn = rr;
		if (gg > mx) mx = gg;
		if (bb > mx) mx = bb;
		if (gg < mn) mn = gg;
		if (bb < mn) mn = bb;
		delta = mx - mn;
		sum = mx + mn;
		res = '0;
		res.lig = LIG_W'(div_half_up(sum * FRAC_SCALE, 510));
		if (delta != 0) begin
			den = (sum < 255) ? sum : 510 - sum;
			res.sat = QUO_W'(div_half_up(delta * FRAC_SCALE, den));
			// red wins ties over green, green over blue
			if (mx == rr) begin
				num = HUE_SECTOR * (gg - bb);
				if (gg < bb) num += longint'(HUE_FULL) * delta;
			end else if (mx == gg) begin
				num = HUE_SECTOR * (bb - rr) + 2 * HUE_SECTOR * delta;
			end else begin
				num = HUE_SECTOR * (rr - gg) + 4 * HUE_SECTOR * delta;
			end
			h = div_half_up(num, delta);
			if (h >= longint'(HUE_FULL)) h -= longint'(HUE_FULL);
			res.hue = HUE_W'(h);
		end
		return res;
	endfunction

	// mostly back-to-back, some short gaps, a few long ones, and idle-free bursts
	function automatic int next_gap();
		int pick;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (pick < 50) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input hsl_t want);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (busy);
		color_q.push_back(want);
		pixels_sent++;
		if (r == g && g == b) gray_sent++;
		else if (r == g || g == b || r == b) tie_sent++;
	endtask

	task automatic hold_until_drained();
		start <= 1'b0;
		while (color_q.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd127;
			3: return 8'd128;
			4: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	task automatic make_pixel(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
		logic [7:0] v;
		int mode;
		mode = $urandom_range(0, 9);
		r = 8'($urandom_range(0, 255));
		g = 8'($urandom_range(0, 255));
		b = 8'($urandom_range(0, 255));
		case (mode)
			6: begin
				g = r;
				b = r;
			end
			7: begin
				// two channels share the maximum, the third sits below
				v = 8'($urandom_range(1, 255));
				case ($urandom_range(0, 2))
					0: begin r = v; g = v; b = 8'($urandom_range(0, v - 1)); end
					1: begin g = v; b = v; r = 8'($urandom_range(0, v - 1)); end
					default: begin r = v; b = v; g = 8'($urandom_range(0, v - 1)); end
				endcase
			end
			8: begin
				r = pick_extreme();
				g = pick_extreme();
				b = pick_extreme();
			end
			9: begin
				// nearly gray: tiny delta stresses the hue divide
				g = r ^ 8'($urandom_range(0, 3));
				b = r ^ 8'($urandom_range(0, 3));
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin : color_check
		hsl_t want;
		if (arst_n && done) begin
			if (color_q.size() == 0) begin
				$error("color word with no pixel pending: hue=%0d sat=%0d lig=%0d",
					hue, saturation, lightness);
				errors++;
			end else begin
				want = color_q.pop_front();
				colors_seen++;
				if (hue !== want.hue) begin
					$error("hue: expected %0d, got %0d", want.hue, hue);
					errors++;
				end
				if (saturation !== want.sat) begin
					$error("saturation: expected %0d, got %0d", want.sat, saturation);
					errors++;
				end
				if (lightness !== want.lig) begin
					$error("lightness: expected %0d, got %0d", want.lig, lightness);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] r, g, b;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].typed)
				send_pixel(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b, DIRECTED[i].want);
			else
				send_pixel(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b,
					predict_hsl(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b));
		end
		hold_until_drained();

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			if (i == RANDOM_PIXELS / 2) hold_until_drained();
			make_pixel(r, g, b);
			send_pixel(r, g, b, predict_hsl(r, g, b));
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d pixels into %0d colors (%0d gray, %0d with tied channels).",
			pixels_sent, colors_seen, gray_sent, tie_sent);
		$display("Mismatches or stray words: %0d, colors still pending: %0d.",
			errors, color_q.size());
		if (errors == 0 && color_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
